// File: design/dgsp_pkg.sv
package dgsp_pkg;

  localparam int MAX_VERTICES  = 64;
  localparam int WEIGHT_BITS   = 16;
  localparam int DISTANCE_BITS = 22;

  // fixed field widths of the channels and the register
  localparam int VTX_W = 6;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam int VIDX_W  = $clog2(MAX_VERTICES);
  localparam int NCNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int WDEPTH  = MAX_VERTICES * MAX_VERTICES;
  localparam int WADDR_W = $clog2(WDEPTH);
  localparam int SUM_W   = ((WEIGHT_BITS > DISTANCE_BITS) ? WEIGHT_BITS : DISTANCE_BITS) + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  typedef logic [DISTANCE_BITS-1:0] dist_t;
  typedef logic [WEIGHT_BITS-1:0]   weight_t;
  typedef logic [VIDX_W-1:0]        vidx_t;
  typedef logic [NCNT_W-1:0]        ncnt_t;
  typedef logic [WADDR_W-1:0]       waddr_t;

  localparam dist_t DIST_MAX = {DISTANCE_BITS{1'b1}};

  typedef struct packed {
    logic    present;
    weight_t wt;
  } wentry_t;

  typedef struct packed {
    logic  conf;
    logic  reach;
    dist_t plen;
    logic  hasp;
    vidx_t pred;
  } ventry_t;

  typedef struct packed {
    logic    we;
    waddr_t  waddr;
    wentry_t wdata;
    logic    re;
    waddr_t  raddr;
  } wram_req_t;

  function automatic dist_t sat_add(dist_t a, weight_t b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > SUM_W'(DIST_MAX)) return DIST_MAX;
    return s[DISTANCE_BITS-1:0];
  endfunction

  function automatic waddr_t cell_addr(vidx_t row, vidx_t col);
    return WADDR_W'(row) * WADDR_W'(MAX_VERTICES) + WADDR_W'(col);
  endfunction

endpackage

// File: design/dgsp_in_if.sv
interface dgsp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [dgsp_pkg::VTX_W-1:0] from_vertex;
  logic [dgsp_pkg::VTX_W-1:0] to_vertex;
  logic [15:0]                weight;
  logic                       edge_present;
  logic [dgsp_pkg::VTX_W-1:0] source_vertex;

  modport source (output valid, op, from_vertex, to_vertex, weight, edge_present,
                  source_vertex, input ready);
  modport sink   (input valid, op, from_vertex, to_vertex, weight, edge_present,
                  source_vertex, output ready);
endinterface

// File: design/dgsp_out_if.sv
interface dgsp_out_if;
  logic                       valid;
  logic                       ready;
  logic [dgsp_pkg::VTX_W-1:0] vertex;
  logic [21:0]                distance;
  logic                       reachable;
  logic [dgsp_pkg::VTX_W-1:0] predecessor;
  logic                       has_predecessor;
  logic                       last;

  modport source (output valid, vertex, distance, reachable, predecessor,
                  has_predecessor, last, input ready);
  modport sink   (input valid, vertex, distance, reachable, predecessor,
                  has_predecessor, last, output ready);
endinterface

// File: design/dgsp_weight_ram.sv
module dgsp_weight_ram (
  input  logic                clk,
  input  dgsp_pkg::wram_req_t req,
  output dgsp_pkg::wentry_t   rdata
);

  dgsp_pkg::wentry_t mem [dgsp_pkg::WDEPTH];
  dgsp_pkg::wentry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/dense_graph_shortest_path_top.sv
// Channel  Dir  Payload                                              Handshake
// in_ch    in   op, from_vertex, to_vertex, weight, edge_present,    valid/ready
//               source_vertex
// out_ch   out  vertex, distance, reachable, predecessor,            valid/ready
//               has_predecessor, last
// cfg      in   cfg_wdata (vertex_count)                             cfg_we
//
// A run is an init scan, then rounds of a minimum scan and, if the chosen vertex is
// reachable, a relaxation scan, one vertex a cycle, bound by the single read port
// of the vertex store and of the weight RAM. Results then leave one at a time,
// each read in S_OUT_RD and loaded in S_OUT_LD, held by a downstream stall.
// After reset the weight RAM is cleared, one entry a cycle for all 4096 entries, and
// no request is taken meanwhile. in_ch.ready is high only between requests.
module dense_graph_shortest_path_top (
  input  logic                         clk,
  input  logic                         rst_n,
  dgsp_in_if.sink                      in_ch,
  dgsp_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [dgsp_pkg::CFG_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_INIT, S_SEL, S_CONF, S_RELAX, S_OUT_RD, S_OUT_LD
  } state_t;

  state_t state_r, state_nxt;

  logic [dgsp_pkg::CFG_W-1:0] cfg_r;
  dgsp_pkg::waddr_t  clr_r, clr_nxt;
  dgsp_pkg::ncnt_t   scan_r, scan_nxt;
  dgsp_pkg::ncnt_t   round_r, round_nxt;
  logic              pv_r, pv_nxt;
  dgsp_pkg::vidx_t   pidx_r, pidx_nxt;
  dgsp_pkg::vidx_t   src_r, src_nxt;
  logic              best_found_r, best_found_nxt;
  dgsp_pkg::vidx_t   best_v_r, best_v_nxt;
  dgsp_pkg::ventry_t best_word_r, best_word_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [dgsp_pkg::VTX_W-1:0] out_vertex_r, out_vertex_nxt;
  dgsp_pkg::dist_t            out_distance_r, out_distance_nxt;
  logic                       out_reachable_r, out_reachable_nxt;
  logic [dgsp_pkg::VTX_W-1:0] out_pred_r, out_pred_nxt;
  logic                       out_hasp_r, out_hasp_nxt;
  logic                       out_last_r, out_last_nxt;

  dgsp_pkg::wram_req_t wreq;
  dgsp_pkg::wentry_t   wram_q;

  dgsp_pkg::ventry_t st_mem [dgsp_pkg::MAX_VERTICES];
  dgsp_pkg::ventry_t st_q;
  logic              st_we, st_re;
  dgsp_pkg::vidx_t   st_waddr, st_raddr;
  dgsp_pkg::ventry_t st_wdata;

  dgsp_pkg::ncnt_t n_c;
  logic            in_ready;
  logic            scan_more;
  dgsp_pkg::vidx_t scan_idx;
  dgsp_pkg::vidx_t row;
  dgsp_pkg::dist_t cand;
  logic            take;

  dgsp_weight_ram u_wram (
    .clk   (clk),
    .req   (wreq),
    .rdata (wram_q)
  );

  // zero acts as one vertex, anything above the array size as the full array
  always_comb begin
    if (cfg_r == '0) begin
      n_c = dgsp_pkg::NCNT_W'(1);
    end else if (int'(cfg_r) > dgsp_pkg::MAX_VERTICES) begin
      n_c = dgsp_pkg::NCNT_W'(dgsp_pkg::MAX_VERTICES);
    end else begin
      n_c = dgsp_pkg::NCNT_W'(cfg_r);
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign scan_more = (scan_r < n_c);
  assign scan_idx  = scan_r[dgsp_pkg::VIDX_W-1:0];
  assign row       = (state_r == S_INIT) ? src_r : best_v_r;
  assign cand      = dgsp_pkg::sat_add(best_word_r.plen, wram_q.wt);

  // highest index wins ties; any finite distance beats an infinite one
  assign take = !best_found_r ||
                (st_q.reach ? (!best_word_r.reach || (st_q.plen <= best_word_r.plen))
                            : !best_word_r.reach);

  always_comb begin
    state_nxt         = state_r;
    clr_nxt           = clr_r;
    scan_nxt          = scan_r;
    round_nxt         = round_r;
    pv_nxt            = pv_r;
    pidx_nxt          = pidx_r;
    src_nxt           = src_r;
    best_found_nxt    = best_found_r;
    best_v_nxt        = best_v_r;
    best_word_nxt     = best_word_r;
    out_valid_nxt     = out_valid_r;
    out_vertex_nxt    = out_vertex_r;
    out_distance_nxt  = out_distance_r;
    out_reachable_nxt = out_reachable_r;
    out_pred_nxt      = out_pred_r;
    out_hasp_nxt      = out_hasp_r;
    out_last_nxt      = out_last_r;

    wreq       = '0;
    wreq.raddr = dgsp_pkg::cell_addr(row, scan_idx);
    st_we      = 1'b0;
    st_waddr   = pidx_r;
    st_wdata   = '0;
    st_re      = 1'b0;
    st_raddr   = scan_idx;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // scan states issue one read a cycle and process the data in the following cycle
    if (state_r == S_INIT || state_r == S_SEL || state_r == S_RELAX) begin
      pv_nxt = scan_more;
      if (scan_more) begin
        scan_nxt = scan_r + dgsp_pkg::NCNT_W'(1);
        pidx_nxt = scan_idx;
      end
    end

    case (state_r)
      S_CLEAR: begin
        wreq.we    = 1'b1;
        wreq.waddr = clr_r;
        clr_nxt    = clr_r + dgsp_pkg::WADDR_W'(1);
        if (clr_r == dgsp_pkg::WADDR_W'(dgsp_pkg::WDEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.op == dgsp_pkg::OP_WRITE) begin
            if (int'(in_ch.from_vertex) < dgsp_pkg::MAX_VERTICES &&
                int'(in_ch.to_vertex) < dgsp_pkg::MAX_VERTICES) begin
              wreq.we    = 1'b1;
              wreq.waddr = dgsp_pkg::cell_addr(
                             dgsp_pkg::VIDX_W'(in_ch.from_vertex),
                             dgsp_pkg::VIDX_W'(in_ch.to_vertex));
              wreq.wdata.present = in_ch.edge_present;
              wreq.wdata.wt      = in_ch.edge_present ?
                                   dgsp_pkg::WEIGHT_BITS'(in_ch.weight) : '0;
            end
          end else if (int'(in_ch.source_vertex) < int'(n_c)) begin
            src_nxt   = dgsp_pkg::VIDX_W'(in_ch.source_vertex);
            scan_nxt  = '0;
            pv_nxt    = 1'b0;
            state_nxt = S_INIT;
          end
        end
      end

      S_INIT: begin
        wreq.re = scan_more;
        if (pv_r) begin
          st_we          = 1'b1;
          st_wdata.conf  = (pidx_r == src_r);
          st_wdata.reach = wram_q.present || (pidx_r == src_r);
          st_wdata.plen  = (pidx_r == src_r || !wram_q.present) ? '0 :
                           dgsp_pkg::sat_add('0, wram_q.wt);
          st_wdata.hasp  = wram_q.present;
          st_wdata.pred  = wram_q.present ? src_r : '0;
        end
        if (!scan_more && !pv_r) begin
          round_nxt      = dgsp_pkg::NCNT_W'(1);
          scan_nxt       = '0;
          best_found_nxt = 1'b0;
          state_nxt      = (n_c == dgsp_pkg::NCNT_W'(1)) ? S_OUT_RD : S_SEL;
        end
      end

      S_SEL: begin
        st_re = scan_more;
        if (pv_r && !st_q.conf && take) begin
          best_found_nxt = 1'b1;
          best_v_nxt     = pidx_r;
          best_word_nxt  = st_q;
        end
        if (!scan_more && !pv_r) begin
          scan_nxt  = '0;
          state_nxt = best_found_r ? S_CONF : S_OUT_RD;
        end
      end

      S_CONF: begin
        st_we         = 1'b1;
        st_waddr      = best_v_r;
        st_wdata      = best_word_r;
        st_wdata.conf = 1'b1;
        scan_nxt      = '0;
        pv_nxt        = 1'b0;
        if (best_word_r.reach) begin
          state_nxt = S_RELAX;
        end else if (round_r == n_c - dgsp_pkg::NCNT_W'(1)) begin
          state_nxt = S_OUT_RD;
        end else begin
          round_nxt      = round_r + dgsp_pkg::NCNT_W'(1);
          best_found_nxt = 1'b0;
          state_nxt      = S_SEL;
        end
      end

      S_RELAX: begin
        wreq.re = scan_more;
        st_re   = scan_more;
        if (pv_r && wram_q.present && !st_q.conf &&
            (!st_q.reach || st_q.plen > cand)) begin
          st_we          = 1'b1;
          st_wdata.reach = 1'b1;
          st_wdata.plen  = cand;
          st_wdata.hasp  = 1'b1;
          st_wdata.pred  = best_v_r;
        end
        if (!scan_more && !pv_r) begin
          scan_nxt = '0;
          if (round_r == n_c - dgsp_pkg::NCNT_W'(1)) begin
            state_nxt = S_OUT_RD;
          end else begin
            round_nxt      = round_r + dgsp_pkg::NCNT_W'(1);
            best_found_nxt = 1'b0;
            state_nxt      = S_SEL;
          end
        end
      end

      S_OUT_RD: begin
        st_re     = 1'b1;
        state_nxt = S_OUT_LD;
      end

      S_OUT_LD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt     = 1'b1;
          out_vertex_nxt    = dgsp_pkg::VTX_W'(scan_idx);
          out_distance_nxt  = st_q.reach ? st_q.plen : dgsp_pkg::DIST_MAX;
          out_reachable_nxt = st_q.reach;
          out_pred_nxt      = st_q.hasp ? dgsp_pkg::VTX_W'(st_q.pred) : '0;
          out_hasp_nxt      = st_q.hasp;
          out_last_nxt      = (scan_r == n_c - dgsp_pkg::NCNT_W'(1));
          if (scan_r == n_c - dgsp_pkg::NCNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            scan_nxt  = scan_r + dgsp_pkg::NCNT_W'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cfg_r        <= dgsp_pkg::CFG_RESET;
      clr_r        <= '0;
      scan_r       <= '0;
      round_r      <= '0;
      pv_r         <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      clr_r        <= clr_nxt;
      scan_r       <= scan_nxt;
      round_r      <= round_nxt;
      pv_r         <= pv_nxt;
      best_found_r <= best_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pidx_r          <= pidx_nxt;
    src_r           <= src_nxt;
    best_v_r        <= best_v_nxt;
    best_word_r     <= best_word_nxt;
    out_vertex_r    <= out_vertex_nxt;
    out_distance_r  <= out_distance_nxt;
    out_reachable_r <= out_reachable_nxt;
    out_pred_r      <= out_pred_nxt;
    out_hasp_r      <= out_hasp_nxt;
    out_last_r      <= out_last_nxt;
  end

  // per-vertex working store
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_q <= st_mem[st_raddr];
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.vertex          = out_vertex_r;
  assign out_ch.distance        = 22'(out_distance_r);
  assign out_ch.reachable       = out_reachable_r;
  assign out_ch.predecessor     = out_pred_r;
  assign out_ch.has_predecessor = out_hasp_r;
  assign out_ch.last            = out_last_r;

endmodule
